// ----- design/tmbt_pkg.sv -----
// Shared constants, types and helpers for the touch median baseline tracker.
// No dependencies; imported by tmbt_median and the top level.
`default_nettype none

package tmbt_pkg;

  // block sizing
  localparam int CHANNELS    = 10;
  localparam int TAPS        = 5;
  localparam int SAMPLE_BITS = 16;

  // fixed field widths of the stream words
  localparam int NUM_FIELDS = 5;
  localparam int CHAN_W     = 4;
  localparam int FIELD_W    = 16;
  localparam int LEVEL_W    = 17;
  localparam int FLOOR_W    = 16;

  // taps actually used by the median, and the rank that selects it
  localparam int NTAP       = (TAPS < NUM_FIELDS) ? TAPS : NUM_FIELDS;
  localparam int MED_RANK   = NTAP / 2;
  localparam int RANK_W     = $clog2(NTAP + 1);

  // channel index width into the baseline memory
  localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // packed stream widths, rounded up to whole bytes
  localparam int IN_BITS    = CHAN_W + NUM_FIELDS * FIELD_W;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = CHAN_W + LEVEL_W + FLOOR_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // item kinds carried in tuser
  localparam logic OP_READING = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [CH_IDX_W-1:0]    ch_idx_t;

  // controller states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_UPD  = 4'b0010,
    ST_TRD  = 4'b0100,
    ST_TWR  = 4'b1000
  } state_t;

endpackage : tmbt_pkg

`default_nettype wire

// ----- design/tmbt_median.sv -----
// Median selector over the first NTAP samples of a reading, by stable ranking.
// Depends on tmbt_pkg.
`default_nettype none

module tmbt_median (
  input  tmbt_pkg::sample_t samples [tmbt_pkg::NUM_FIELDS],
  output tmbt_pkg::sample_t med
);
  import tmbt_pkg::*;

  logic [RANK_W-1:0] rank [NTAP];

  // stable rank: earlier equal values count as smaller, so ranks form a permutation
  always_comb begin
    for (int i = 0; i < NTAP; i++) begin
      rank[i] = '0;
      for (int j = 0; j < NTAP; j++) begin
        if (j < i) begin
          if (samples[j] <= samples[i]) rank[i] = rank[i] + 1'b1;
        end else if (j > i) begin
          if (samples[j] < samples[i]) rank[i] = rank[i] + 1'b1;
        end
      end
    end
  end

  // pick the sample whose rank is the middle one
  always_comb begin
    med = samples[0];
    for (int i = 0; i < NTAP; i++) begin
      if (rank[i] == RANK_W'(MED_RANK)) med = samples[i];
    end
  end

endmodule : tmbt_median

`default_nettype wire

// ----- design/tmbt_floor_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the per-channel baselines; no dependencies.
`default_nettype none

module tmbt_floor_ram #(
  parameter int DEPTH = 10,
  parameter int WIDTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : tmbt_floor_ram

`default_nettype wire

// ----- design/touch_median_baseline_tracker.sv -----
// Top level of the touch median baseline tracker: stream ports, controller,
// baseline memory and median selector. Depends on tmbt_pkg, tmbt_median, tmbt_floor_ram.
//
// Usage:
//   Input stream s_*: tuser selects the kind of word, 0 = reading, 1 = one-second
//   tick. A reading carries a channel and five raw counts in tdata. Each reading
//   for a valid channel gives one output word on m_*: channel, level (median
//   minus the updated baseline) and the updated baseline. Ticks and readings for
//   channels beyond the last one give no output word.
//   An accepted reading is read from the baseline memory, then the update step
//   loads the output register that drives m_tvalid once that register is free.
//   s_tready stays low until an item is done: a reading takes a memory read,
//   then modify and write back; a tick reads and writes each channel in turn.
//   The output register holds one finished word; the block keeps accepting
//   input while it waits. A second reading that finishes while the receiver
//   stalls waits in the update step, and s_tready stays low until the word moves.
//   Reset clears all baseline valid flags at once; no clearing pass is needed
//   and the block is ready in the first cycle after reset.
`default_nettype none

module touch_median_baseline_tracker (
  input  logic                           clk,
  input  logic                           rst,
  // s_tdata: channel[3:0], sample_a[19:4], sample_b[35:20], sample_c[51:36],
  //          sample_d[67:52], sample_e[83:68], zero pad[87:84]
  input  logic [tmbt_pkg::IN_DATA_W-1:0]  s_tdata,
  // s_tuser: opcode[0]
  input  logic                           s_tuser,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // m_tdata: out_channel[3:0], level[20:4], floor_value[36:21], zero pad[39:37]
  output logic [tmbt_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready
);
  import tmbt_pkg::*;

  // unpack input word
  logic [CHAN_W-1:0] in_channel;
  sample_t           in_samples [NUM_FIELDS];
  logic              in_accept;
  logic              in_valid_ch;

  assign in_channel = s_tdata[CHAN_W-1:0];
  always_comb begin
    for (int i = 0; i < NUM_FIELDS; i++) begin
      in_samples[i] = SAMPLE_BITS'(s_tdata[CHAN_W + i*FIELD_W +: FIELD_W]);
    end
  end
  assign in_accept   = s_tvalid && s_tready;
  assign in_valid_ch = (32'(in_channel) < CHANNELS);

  // median of the incoming reading
  sample_t in_med;
  tmbt_median u_median (
    .samples (in_samples),
    .med     (in_med)
  );

  // controller state
  state_t            state, state_next;
  sample_t           med_r;
  ch_idx_t           ch_r;
  ch_idx_t           cnt;
  logic [CHANNELS-1:0] floor_set;

  // baseline memory
  logic    ram_we, ram_re;
  ch_idx_t ram_waddr, ram_raddr;
  sample_t ram_wdata, ram_rdata;

  tmbt_floor_ram #(
    .DEPTH (CHANNELS),
    .WIDTH (SAMPLE_BITS)
  ) u_floor_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register
  logic [CHAN_W-1:0]  out_channel;
  logic [LEVEL_W-1:0] level;
  logic [FLOOR_W-1:0] floor_value;
  logic               out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  // baseline update for a reading
  sample_t                 upd_floor;
  logic signed [SAMPLE_BITS:0] upd_diff;
  logic                    upd_fire;

  always_comb begin
    if (!floor_set[ch_r]) begin
      upd_floor = med_r;
    end else if (ram_rdata > med_r) begin
      upd_floor = ram_rdata - 1'b1;
    end else begin
      upd_floor = ram_rdata;
    end
    upd_diff = $signed({1'b0, med_r}) - $signed({1'b0, upd_floor});
  end
  assign upd_fire = (state == ST_UPD) && out_free;

  // tick raise of one channel
  logic tick_inc;
  assign tick_inc = floor_set[cnt] && (ram_rdata != SAMPLE_MAX);

  // memory port selection
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = cnt;
    ram_we    = 1'b0;
    ram_waddr = cnt;
    ram_wdata = ram_rdata + 1'b1;
    case (state)
      ST_IDLE: begin
        ram_re    = in_accept && (s_tuser == OP_READING) && in_valid_ch;
        ram_raddr = CH_IDX_W'(in_channel);
      end
      ST_UPD: begin
        ram_we    = upd_fire;
        ram_waddr = ch_r;
        ram_wdata = upd_floor;
      end
      ST_TRD: begin
        ram_re = 1'b1;
      end
      ST_TWR: begin
        ram_we = tick_inc;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          if (s_tuser == OP_TICK) begin
            state_next = ST_TRD;
          end else if (in_valid_ch) begin
            state_next = ST_UPD;
          end
        end
      end
      ST_UPD: begin
        if (out_free) state_next = ST_IDLE;
      end
      ST_TRD: begin
        state_next = ST_TWR;
      end
      ST_TWR: begin
        if (cnt == CH_IDX_W'(CHANNELS - 1)) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_TRD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      floor_set <= '0;
      cnt       <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        cnt <= '0;
      end else if (state == ST_TWR) begin
        cnt <= cnt + 1'b1;
      end
      if (upd_fire) begin
        floor_set[ch_r] <= 1'b1;
      end
      if (upd_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      med_r <= in_med;
      ch_r  <= CH_IDX_W'(in_channel);
    end
    if (upd_fire) begin
      out_channel <= CHAN_W'(ch_r);
      level       <= LEVEL_W'(upd_diff);
      floor_value <= FLOOR_W'(upd_floor);
    end
  end

  assign m_tdata = OUT_DATA_W'({floor_value, level, out_channel});

endmodule : touch_median_baseline_tracker

`default_nettype wire
